>>> sv/phc_pkg.sv
// Shared types and constants for the probed hash cache.
package phc_pkg;

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_DECAY  = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    localparam logic [7:0] USES_MAX = 8'd255;

    typedef struct packed {
        logic [31:0] hash;
        logic [31:0] tag;
        logic [31:0] value;
        logic [7:0]  uses;
    } slot_t;

endpackage

>>> sv/probed_hash_cache_with_decay.sv
// Probed hash cache with use-count decay: sequencer, slot memory and result register.
//
// Open-addressed cache of SLOTS entries held in one slot memory (one read and one
// write port, registered read). After a lookup or insert is accepted, S_HASH1,
// S_HASH2 and S_BASE reduce the hash modulo SLOTS through a reciprocal multiply,
// then S_PROBE issues one memory read per probed slot, up to PROBE_WINDOW slots,
// and evaluates each as its data returns, then S_RESULT loads the result register;
// a lookup or insert that ends early on an empty or matching slot finishes sooner.
// While disabled, every item but a clear goes straight to S_RESULT. A frame-end
// decay reads DECAY_PER_FRAME slots and writes each back with its nonzero use count
// one lower. A clear sweeps the memory one slot per cycle. The next item is taken once
// the result register loads. After reset the same sweep runs before the first
// item is taken; configuration writes are taken at any time. A finished result waits
// in the output register, so the next item is accepted while it is still stalled.
module probed_hash_cache_with_decay #(
    parameter int SLOTS           = 128,
    parameter int PROBE_WINDOW    = 4,
    parameter int DECAY_PER_FRAME = 8
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,

    input  logic        item_valid,
    output logic        item_stall,
    input  logic [1:0]  opcode,
    input  logic [31:0] key_hash,
    input  logic [31:0] key_tag,
    input  logic [31:0] value_in,

    output logic        result_valid,
    input  logic        result_stall,
    output logic        hit,
    output logic [31:0] value_out,
    output logic [31:0] total_hits,
    output logic [31:0] total_misses
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int REM_W = IDX_W + 1;
    localparam int PC_W  = $clog2(PROBE_WINDOW + 1);
    localparam int DC_W  = $clog2(DECAY_PER_FRAME + 1);

    localparam logic [31:0]      HASH_RECIP = 32'((64'd1 << 32) / SLOTS);
    localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(SLOTS - 1);
    localparam logic [REM_W-1:0] SLOTS_R    = REM_W'(SLOTS);
    localparam logic [PC_W-1:0]  PW_CNT     = PC_W'(PROBE_WINDOW);
    localparam logic [PC_W-1:0]  PW_LAST    = PC_W'(PROBE_WINDOW - 1);
    localparam logic [DC_W-1:0]  DPF_LAST   = DC_W'(DECAY_PER_FRAME - 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CLEAR  = 4'd1;
    localparam logic [3:0] S_HASH1  = 4'd2;
    localparam logic [3:0] S_HASH2  = 4'd3;
    localparam logic [3:0] S_BASE   = 4'd4;
    localparam logic [3:0] S_PROBE  = 4'd5;
    localparam logic [3:0] S_DEC_RD = 4'd6;
    localparam logic [3:0] S_DEC_WR = 4'd7;
    localparam logic [3:0] S_RESULT = 4'd8;

    // control state
    logic [3:0]       state_reg,      state_next;
    logic [IDX_W-1:0] clr_idx_reg,    clr_idx_next;
    logic             clr_res_reg,    clr_res_next;
    logic             enable_reg,     enable_next;
    logic [PC_W-1:0]  rd_cnt_reg,     rd_cnt_next;
    logic [PC_W-1:0]  ev_cnt_reg,     ev_cnt_next;
    logic             rvalid_reg,     rvalid_next;
    logic [DC_W-1:0]  dec_cnt_reg,    dec_cnt_next;
    logic [IDX_W-1:0] decay_ptr_reg,  decay_ptr_next;
    logic [31:0]      hit_cnt_reg,    hit_cnt_next;
    logic [31:0]      miss_cnt_reg,   miss_cnt_next;
    logic             res_valid_reg,  res_valid_next;

    // payload
    logic [1:0]       op_reg,         op_next;
    logic [31:0]      hash_reg,       hash_next;
    logic [31:0]      tag_reg,        tag_next;
    logic [31:0]      val_reg,        val_next;
    logic [REM_W-1:0] q_reg,          q_next;
    logic [REM_W-1:0] rem_reg,        rem_next;
    logic [IDX_W-1:0] rd_idx_reg,     rd_idx_next;
    logic [IDX_W-1:0] ridx_reg,       ridx_next;
    logic [7:0]       best_reg,       best_next;
    logic [IDX_W-1:0] victim_reg,     victim_next;
    logic             found_reg,      found_next;
    logic             res_hit_reg,    res_hit_next;
    logic [31:0]      res_val_reg,    res_val_next;
    logic             out_hit_reg,    out_hit_next;
    logic [31:0]      out_val_reg,    out_val_next;
    logic [31:0]      out_hits_reg,   out_hits_next;
    logic [31:0]      out_misses_reg, out_misses_next;

    // slot memory
    phc_pkg::slot_t   slot_mem [SLOTS];
    phc_pkg::slot_t   mem_rdata;
    phc_pkg::slot_t   mem_wdata;
    logic             mem_we;
    logic             mem_re;
    logic [IDX_W-1:0] mem_waddr;
    logic [IDX_W-1:0] mem_raddr;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata <= slot_mem[mem_raddr];
        end
    end

    logic [63:0]      recip_prod;
    logic [REM_W-1:0] q_times_slots;
    phc_pkg::slot_t   fill_entry;
    logic             rd_empty;
    logic             rd_match;
    logic             rd_lower;
    logic             probe_issue;

    assign recip_prod    = 64'(hash_reg) * 64'(HASH_RECIP);
    assign q_times_slots = q_reg * SLOTS_R;
    assign fill_entry    = '{hash: hash_reg, tag: tag_reg, value: val_reg, uses: 8'd1};
    assign rd_empty      = (mem_rdata.hash == 32'd0);
    assign rd_match      = (mem_rdata.hash == hash_reg) && (mem_rdata.tag == tag_reg);
    assign rd_lower      = (mem_rdata.uses < best_reg);
    assign probe_issue   = (rd_cnt_reg != PW_CNT);

    always_comb
    begin
        state_next      = state_reg;
        clr_idx_next    = clr_idx_reg;
        clr_res_next    = clr_res_reg;
        enable_next     = enable_reg;
        rd_cnt_next     = rd_cnt_reg;
        ev_cnt_next     = ev_cnt_reg;
        rvalid_next     = rvalid_reg;
        dec_cnt_next    = dec_cnt_reg;
        decay_ptr_next  = decay_ptr_reg;
        hit_cnt_next    = hit_cnt_reg;
        miss_cnt_next   = miss_cnt_reg;
        res_valid_next  = res_valid_reg;
        op_next         = op_reg;
        hash_next       = hash_reg;
        tag_next        = tag_reg;
        val_next        = val_reg;
        q_next          = q_reg;
        rem_next        = rem_reg;
        rd_idx_next     = rd_idx_reg;
        ridx_next       = ridx_reg;
        best_next       = best_reg;
        victim_next     = victim_reg;
        found_next      = found_reg;
        res_hit_next    = res_hit_reg;
        res_val_next    = res_val_reg;
        out_hit_next    = out_hit_reg;
        out_val_next    = out_val_reg;
        out_hits_next   = out_hits_reg;
        out_misses_next = out_misses_reg;
        mem_we          = 1'b0;
        mem_waddr       = ridx_reg;
        mem_wdata       = fill_entry;
        mem_re          = 1'b0;
        mem_raddr       = rd_idx_reg;

        if (cfg_wr_en)
        begin
            enable_next = cfg_wr_data;
        end

        if (res_valid_reg && !result_stall)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    op_next      = opcode;
                    hash_next    = (key_hash == 32'd0) ? 32'd1 : key_hash;
                    tag_next     = key_tag;
                    val_next     = value_in;
                    res_hit_next = 1'b0;
                    res_val_next = 32'd0;
                    priority if (opcode == phc_pkg::OP_CLEAR)
                    begin
                        clr_idx_next = '0;
                        clr_res_next = 1'b1;
                        state_next   = S_CLEAR;
                    end
                    else if (!enable_reg)
                    begin
                        state_next = S_RESULT;
                    end
                    else if (opcode == phc_pkg::OP_DECAY)
                    begin
                        dec_cnt_next = '0;
                        state_next   = S_DEC_RD;
                    end
                    else
                    begin
                        state_next = S_HASH1;
                    end
                end
            end

            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_idx_reg;
                mem_wdata = '0;
                if (clr_idx_reg == LAST_IDX)
                begin
                    state_next = clr_res_reg ? S_RESULT : S_IDLE;
                end
                else
                begin
                    clr_idx_next = clr_idx_reg + 1'b1;
                end
            end

            // quotient estimate is exact or one short; only its low bits matter
            S_HASH1:
            begin
                q_next     = recip_prod[32 +: REM_W];
                state_next = S_HASH2;
            end

            S_HASH2:
            begin
                rem_next   = hash_reg[REM_W-1:0] - q_times_slots;
                state_next = S_BASE;
            end

            S_BASE:
            begin
                rd_idx_next = (rem_reg >= SLOTS_R) ? IDX_W'(rem_reg - SLOTS_R)
                                                   : rem_reg[IDX_W-1:0];
                rd_cnt_next = '0;
                ev_cnt_next = '0;
                rvalid_next = 1'b0;
                best_next   = phc_pkg::USES_MAX;
                found_next  = 1'b0;
                state_next  = S_PROBE;
            end

            // one read issued per cycle, each evaluated when its data returns
            S_PROBE:
            begin
                mem_re      = probe_issue;
                rvalid_next = probe_issue;
                ridx_next   = rd_idx_reg;
                if (probe_issue)
                begin
                    rd_cnt_next = rd_cnt_reg + 1'b1;
                    rd_idx_next = (rd_idx_reg == LAST_IDX) ? '0 : rd_idx_reg + 1'b1;
                end
                if (rvalid_reg)
                begin
                    ev_cnt_next = ev_cnt_reg + 1'b1;
                    if (op_reg == phc_pkg::OP_LOOKUP)
                    begin
                        priority if (rd_empty)
                        begin
                            miss_cnt_next = miss_cnt_reg + 32'd1;
                            state_next    = S_RESULT;
                        end
                        else if (rd_match)
                        begin
                            mem_we    = 1'b1;
                            mem_wdata = mem_rdata;
                            if (mem_rdata.uses != phc_pkg::USES_MAX)
                            begin
                                mem_wdata.uses = mem_rdata.uses + 8'd1;
                            end
                            res_hit_next = 1'b1;
                            res_val_next = mem_rdata.value;
                            hit_cnt_next = hit_cnt_reg + 32'd1;
                            state_next   = S_RESULT;
                        end
                        else if (ev_cnt_reg == PW_LAST)
                        begin
                            miss_cnt_next = miss_cnt_reg + 32'd1;
                            state_next    = S_RESULT;
                        end
                        else
                        begin
                            state_next = S_PROBE;
                        end
                    end
                    else
                    begin
                        if (rd_empty || rd_match)
                        begin
                            mem_we     = 1'b1;
                            state_next = S_RESULT;
                        end
                        else
                        begin
                            if (rd_lower)
                            begin
                                best_next   = mem_rdata.uses;
                                victim_next = ridx_reg;
                                found_next  = 1'b1;
                            end
                            if (ev_cnt_reg == PW_LAST)
                            begin
                                // evict the first slot holding the lowest count, if that count is below USES_MAX
                                mem_we     = found_reg || rd_lower;
                                mem_waddr  = rd_lower ? ridx_reg : victim_reg;
                                state_next = S_RESULT;
                            end
                        end
                    end
                end
            end

            S_DEC_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = decay_ptr_reg;
                state_next = S_DEC_WR;
            end

            S_DEC_WR:
            begin
                mem_waddr      = decay_ptr_reg;
                mem_wdata      = mem_rdata;
                mem_wdata.uses = mem_rdata.uses - 8'd1;
                mem_we         = (mem_rdata.uses != 8'd0);
                decay_ptr_next = (decay_ptr_reg == LAST_IDX) ? '0 : decay_ptr_reg + 1'b1;
                dec_cnt_next   = dec_cnt_reg + 1'b1;
                state_next     = (dec_cnt_reg == DPF_LAST) ? S_RESULT : S_DEC_RD;
            end

            S_RESULT:
            begin
                if (!res_valid_reg || !result_stall)
                begin
                    res_valid_next  = 1'b1;
                    out_hit_next    = res_hit_reg;
                    out_val_next    = res_val_reg;
                    out_hits_next   = hit_cnt_reg;
                    out_misses_next = miss_cnt_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_idx_reg   <= '0;
            clr_res_reg   <= 1'b0;
            enable_reg    <= 1'b0;
            rd_cnt_reg    <= '0;
            ev_cnt_reg    <= '0;
            rvalid_reg    <= 1'b0;
            dec_cnt_reg   <= '0;
            decay_ptr_reg <= '0;
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            clr_res_reg   <= clr_res_next;
            enable_reg    <= enable_next;
            rd_cnt_reg    <= rd_cnt_next;
            ev_cnt_reg    <= ev_cnt_next;
            rvalid_reg    <= rvalid_next;
            dec_cnt_reg   <= dec_cnt_next;
            decay_ptr_reg <= decay_ptr_next;
            hit_cnt_reg   <= hit_cnt_next;
            miss_cnt_reg  <= miss_cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        hash_reg       <= hash_next;
        tag_reg        <= tag_next;
        val_reg        <= val_next;
        q_reg          <= q_next;
        rem_reg        <= rem_next;
        rd_idx_reg     <= rd_idx_next;
        ridx_reg       <= ridx_next;
        best_reg       <= best_next;
        victim_reg     <= victim_next;
        found_reg      <= found_next;
        res_hit_reg    <= res_hit_next;
        res_val_reg    <= res_val_next;
        out_hit_reg    <= out_hit_next;
        out_val_reg    <= out_val_next;
        out_hits_reg   <= out_hits_next;
        out_misses_reg <= out_misses_next;
    end

    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = res_valid_reg;
    assign hit          = out_hit_reg;
    assign value_out    = out_val_reg;
    assign total_hits   = out_hits_reg;
    assign total_misses = out_misses_reg;

    a_probe_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PROBE) |-> (rd_idx_reg <= LAST_IDX))
        else $error("probe index beyond slot count");

    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_CLEAR || state_reg == S_PROBE || state_reg == S_DEC_WR))
        else $error("slot write outside clear, probe or decay");

    a_hit_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (hit_cnt_reg != $past(hit_cnt_reg)) |->
            (hit_cnt_reg == $past(hit_cnt_reg) + 32'd1) && ($past(state_reg) == S_PROBE))
        else $error("hit counter moved outside a probe");

    a_count_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        (hit_cnt_reg != $past(hit_cnt_reg)) |-> (miss_cnt_reg == $past(miss_cnt_reg)))
        else $error("hit and miss counted for one lookup");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESULT && res_valid_reg && result_stall) |=> (state_reg == S_RESULT))
        else $error("result overwrote a stalled transaction");

endmodule

>>> sim/probed_hash_cache_with_decay_test.sv
// Self-checking testbench for the probed hash cache with a use-count predictor and scoreboard.
module probed_hash_cache_with_decay_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS           = 128;
    localparam int WINDOW          = 4;
    localparam int DECAY_PER_FRAME = 8;
    localparam int POOL            = 20;
    localparam int HOLD_CYCLES     = 400;

    typedef struct {
        logic        hit;
        logic [31:0] value;
        logic [31:0] hits;
        logic [31:0] misses;
    } cache_result_t;

    typedef struct {
        logic [31:0] hash;
        logic [31:0] tag;
    } cache_key_t;

    class cache_scoreboard;
        logic [31:0]   s_hash[SLOTS];
        logic [31:0]   s_tag[SLOTS];
        logic [31:0]   s_value[SLOTS];
        logic [7:0]    s_uses[SLOTS];
        int unsigned   decay_ptr;
        logic [31:0]   hit_cnt;
        logic [31:0]   miss_cnt;
        bit            enabled;
        cache_result_t expected_q[$];
        int            mismatches;
        int            accepted;

        function new();
            clear_slots();
            decay_ptr  = 0;
            hit_cnt    = '0;
            miss_cnt   = '0;
            enabled    = 1'b0;
            mismatches = 0;
            accepted   = 0;
        endfunction

        function void clear_slots();
            int i;
            for (i = 0; i < SLOTS; i++)
            begin
                s_hash[i]  = '0;
                s_tag[i]   = '0;
                s_value[i] = '0;
                s_uses[i]  = '0;
            end
        endfunction

        function void fill_slot(int unsigned idx, logic [31:0] h, logic [31:0] t,
                                logic [31:0] v);
            s_hash[idx]  = h;
            s_tag[idx]   = t;
            s_value[idx] = v;
            s_uses[idx]  = 8'd1;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Advance the cache state by one accepted input transaction and queue its result.
        function void note_item(logic [1:0] op, logic [31:0] key_h, logic [31:0] key_t,
                                logic [31:0] val);
            logic [31:0]   h;
            int unsigned   base;
            int unsigned   idx;
            int unsigned   victim;
            logic [7:0]    best;
            bit            done;
            bit            found;
            int            i;
            cache_result_t r;

            h       = (key_h == 32'd0) ? 32'd1 : key_h;
            base    = h % SLOTS;
            r.hit   = 1'b0;
            r.value = '0;
            victim  = 0;
            if (op == phc_pkg::OP_CLEAR)
            begin
                clear_slots();
            end
            else if (enabled)
            begin
                case (op)
                    phc_pkg::OP_LOOKUP:
                    begin
                        done = 1'b0;
                        for (i = 0; i < WINDOW && !done; i++)
                        begin
                            idx = (base + i) % SLOTS;
                            if (s_hash[idx] == 32'd0)
                                done = 1'b1;
                            else if (s_hash[idx] == h && s_tag[idx] == key_t)
                            begin
                                r.hit   = 1'b1;
                                r.value = s_value[idx];
                                if (s_uses[idx] < phc_pkg::USES_MAX)
                                    s_uses[idx] = s_uses[idx] + 8'd1;
                                hit_cnt = hit_cnt + 32'd1;
                                done    = 1'b1;
                            end
                        end
                        if (!r.hit)
                            miss_cnt = miss_cnt + 32'd1;
                    end
                    phc_pkg::OP_INSERT:
                    begin
                        done  = 1'b0;
                        found = 1'b0;
                        best  = phc_pkg::USES_MAX;
                        for (i = 0; i < WINDOW && !done; i++)
                        begin
                            idx = (base + i) % SLOTS;
                            if (s_hash[idx] == 32'd0 ||
                                (s_hash[idx] == h && s_tag[idx] == key_t))
                            begin
                                fill_slot(idx, h, key_t, val);
                                done = 1'b1;
                            end
                            else if (s_uses[idx] < best)
                            begin
                                best   = s_uses[idx];
                                victim = idx;
                                found  = 1'b1;
                            end
                        end
                        // eviction only when the window had no free or matching slot
                        if (!done && found)
                            fill_slot(victim, h, key_t, val);
                    end
                    default:
                    begin
                        for (i = 0; i < DECAY_PER_FRAME; i++)
                        begin
                            if (s_uses[decay_ptr] != 8'd0)
                                s_uses[decay_ptr] = s_uses[decay_ptr] - 8'd1;
                            decay_ptr = (decay_ptr + 1) % SLOTS;
                        end
                    end
                endcase
            end
            r.hits   = hit_cnt;
            r.misses = miss_cnt;
            expected_q.push_back(r);
            accepted++;
        endfunction

        function void check_result(logic hit_o, logic [31:0] value_o, logic [31:0] hits_o,
                                   logic [31:0] misses_o);
            cache_result_t e;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction: hit=%0d value=%h hits=%0d misses=%0d",
                             hit_o, value_o, hits_o, misses_o);
                return;
            end
            e = expected_q.pop_front();
            if (e.hit !== hit_o || e.value !== value_o || e.hits !== hits_o ||
                e.misses !== misses_o)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: expected hit=%0d value=%h hits=%0d misses=%0d, got hit=%0d value=%h hits=%0d misses=%0d",
                             e.hit, e.value, e.hits, e.misses,
                             hit_o, value_o, hits_o, misses_o);
            end
        endfunction
    endclass

    bit          clk = 1'b0;
    logic        rst_n;
    logic        cfg_wr_en;
    logic        cfg_wr_data;
    logic        item_valid;
    logic        item_stall;
    logic [1:0]  opcode;
    logic [31:0] key_hash;
    logic [31:0] key_tag;
    logic [31:0] value_in;
    logic        result_valid;
    logic        result_stall;
    logic        hit;
    logic [31:0] value_out;
    logic [31:0] total_hits;
    logic [31:0] total_misses;

    logic        no_idle;
    logic        hold_off;

    cache_scoreboard sb;
    cache_key_t      key_pool[POOL];

    always #5 clk = ~clk;

    probed_hash_cache_with_decay #(
        .SLOTS           (SLOTS),
        .PROBE_WINDOW    (WINDOW),
        .DECAY_PER_FRAME (DECAY_PER_FRAME)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .opcode       (opcode),
        .key_hash     (key_hash),
        .key_tag      (key_tag),
        .value_in     (value_in),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .hit          (hit),
        .value_out    (value_out),
        .total_hits   (total_hits),
        .total_misses (total_misses)
    );

    // Offer one input transaction and return at the edge where it is taken.
    task automatic send_op(input logic [1:0] op, input logic [31:0] h, input logic [31:0] t,
                           input logic [31:0] v);
        if (!no_idle && $urandom_range(0, 99) < 6)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        item_valid <= 1'b1;
        opcode     <= op;
        key_hash   <= h;
        key_tag    <= t;
        value_in   <= v;
        @(posedge clk);
        while (item_stall !== 1'b0)
            @(posedge clk);
        sb.note_item(op, h, t, v);
    endtask

    task automatic wait_drained();
        item_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_enable(input bit en);
        wait_drained();
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= en;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.enabled = en;
    endtask

    // Pool keys crowd the slots around the wrap point so windows overlap.
    task automatic run_mixed(input int count);
        int         n;
        int         r;
        cache_key_t k;
        for (n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            k = key_pool[$urandom_range(0, POOL - 1)];
            if (r < 45)
                send_op(phc_pkg::OP_LOOKUP, k.hash, k.tag, $urandom());
            else if (r < 80)
                send_op(phc_pkg::OP_INSERT, k.hash, k.tag, $urandom());
            else if (r < 92)
                send_op(phc_pkg::OP_DECAY, $urandom(), $urandom(), $urandom());
            else if (r < 95)
                send_op(phc_pkg::OP_CLEAR, $urandom(), $urandom(), $urandom());
            else
                send_op($urandom_range(0, 1) ? phc_pkg::OP_INSERT : phc_pkg::OP_LOOKUP,
                        $urandom(), $urandom(), $urandom());
        end
    endtask

    initial
    begin
        #3000000;
        $display("probed_hash_cache_with_decay verification failed");
        $finish;
    end

    initial
    begin
        result_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_valid === 1'b1 && result_stall === 1'b0)
                sb.check_result(hit, value_out, total_hits, total_misses);
            result_stall <= hold_off || (!no_idle && $urandom_range(0, 99) < 6);
        end
    end

    // Long receiver hold-offs while the sender keeps offering, to back the block up.
    initial
    begin
        int thresholds[2];
        int k;
        thresholds[0] = 120;
        thresholds[1] = 1000;
        hold_off <= 1'b0;
        wait (rst_n === 1'b1);
        for (k = 0; k < 2; k++)
        begin
            do
                @(posedge clk);
            while (sb.accepted < thresholds[k]);
            hold_off <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_off <= 1'b0;
        end
    end

    initial
    begin
        logic [31:0] hot_hash[4];
        logic [31:0] hot_tag[4];
        logic [31:0] cold_hash[3];
        logic [31:0] cold_tag[3];
        logic [6:0]  bases[10];
        int          i;
        int          n;

        sb = new();
        rst_n       <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= 1'b0;
        item_valid  <= 1'b0;
        opcode      <= phc_pkg::OP_LOOKUP;
        key_hash    <= '0;
        key_tag     <= '0;
        value_in    <= '0;
        no_idle     <= 1'b0;

        bases = '{7'd124, 7'd125, 7'd126, 7'd127, 7'd0, 7'd1, 7'd2, 7'd3, 7'd4, 7'd5};
        for (i = 0; i < POOL; i++)
        begin
            key_pool[i].hash = (i % 3 == 0) ? ($urandom() & 32'hFFFF_FF80)
                                             : ($urandom_range(0, 2) << 7);
            key_pool[i].hash = key_pool[i].hash | 32'(bases[$urandom_range(0, 9)]);
            key_pool[i].tag  = $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 3);
        end
        // a zero hash and a hash of one name the same key
        key_pool[0].hash = 32'd0;
        key_pool[1].hash = 32'd1;
        key_pool[1].tag  = key_pool[0].tag;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // disabled: nothing but clear may act, no miss counted
        send_op(phc_pkg::OP_LOOKUP, 32'd0, 32'd0, 32'd0);
        send_op(phc_pkg::OP_INSERT, 32'd5, 32'h0000_1234, 32'hFFFF_FFFF);
        send_op(phc_pkg::OP_DECAY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(phc_pkg::OP_CLEAR, 32'd0, 32'd0, 32'd0);
        write_enable(1'b1);
        send_op(phc_pkg::OP_LOOKUP, 32'd5, 32'h0000_1234, 32'd0);
        send_op(phc_pkg::OP_INSERT, 32'd0, 32'd0, 32'hFFFF_FFFF);
        send_op(phc_pkg::OP_LOOKUP, 32'd1, 32'd0, 32'd0);
        // window starting at the last slot wraps to the front
        send_op(phc_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
        send_op(phc_pkg::OP_INSERT, 32'h0000_007F, 32'hA5A5_A5A5, 32'h1111_1111);
        send_op(phc_pkg::OP_INSERT, 32'h0000_00FF, 32'h5A5A_5A5A, 32'h2222_2222);
        send_op(phc_pkg::OP_INSERT, 32'h0000_017F, 32'h0F0F_0F0F, 32'h3333_3333);
        send_op(phc_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
        send_op(phc_pkg::OP_LOOKUP, 32'h0000_017F, 32'h0F0F_0F0F, 32'd0);
        send_op(phc_pkg::OP_INSERT, 32'h0000_007F, 32'hA5A5_A5A5, 32'h4444_4444);
        send_op(phc_pkg::OP_LOOKUP, 32'h0000_007F, 32'hA5A5_A5A5, 32'd0);
        send_op(phc_pkg::OP_LOOKUP, 32'h0000_007F, 32'h5A5A_5A5A, 32'd0);
        send_op(phc_pkg::OP_DECAY, 32'd0, 32'd0, 32'd0);
        send_op(phc_pkg::OP_DECAY, 32'd0, 32'd0, 32'd0);
        send_op(phc_pkg::OP_INSERT, 32'h8000_0000, 32'd0, 32'hDEAD_BEEF);
        send_op(phc_pkg::OP_LOOKUP, 32'h8000_0000, 32'd0, 32'd0);
        send_op(phc_pkg::OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(phc_pkg::OP_LOOKUP, 32'h0000_017F, 32'h0F0F_0F0F, 32'd0);
        write_enable(1'b0);
        send_op(phc_pkg::OP_LOOKUP, 32'h8000_0000, 32'd0, 32'd0);
        write_enable(1'b1);

        run_mixed(20);
        write_enable(1'b0);
        run_mixed(6);
        write_enable(1'b1);
        run_mixed(10);

        // Saturation: four keys share one window and are hit until their counts pin.
        wait_drained();
        send_op(phc_pkg::OP_CLEAR, $urandom(), $urandom(), $urandom());
        for (i = 0; i < 4; i++)
        begin
            hot_hash[i] = ($urandom() & 32'hFFFF_FC00) | (i << 7) | 32'd60;
            hot_tag[i]  = $urandom();
            send_op(phc_pkg::OP_INSERT, hot_hash[i], hot_tag[i], $urandom());
        end
        for (i = 0; i < 3; i++)
        begin
            cold_hash[i] = ($urandom() & 32'hFFFF_FC00) | ((i + 4) << 7) | 32'd60;
            cold_tag[i]  = $urandom();
        end
        no_idle <= 1'b1;
        // 255 hits per key: the last one lands on a pinned count
        for (n = 0; n < 1020; n++)
        begin
            if (n == 300)
                no_idle <= 1'b0;
            send_op(phc_pkg::OP_LOOKUP, hot_hash[n % 4], hot_tag[n % 4], $urandom());
        end
        // every slot of the window pinned: inserts store nothing
        for (i = 0; i < 3; i++)
            send_op(phc_pkg::OP_INSERT, cold_hash[i], cold_tag[i], $urandom());
        for (i = 0; i < 3; i++)
            send_op(phc_pkg::OP_LOOKUP, cold_hash[i], cold_tag[i], $urandom());
        // one full decay sweep brings all to one below the cap, first slot is evicted
        for (n = 0; n < SLOTS / DECAY_PER_FRAME; n++)
            send_op(phc_pkg::OP_DECAY, $urandom(), $urandom(), $urandom());
        send_op(phc_pkg::OP_INSERT, cold_hash[0], cold_tag[0], $urandom());
        send_op(phc_pkg::OP_LOOKUP, hot_hash[0], hot_tag[0], $urandom());
        send_op(phc_pkg::OP_LOOKUP, cold_hash[0], cold_tag[0], $urandom());
        send_op(phc_pkg::OP_LOOKUP, hot_hash[1], hot_tag[1], $urandom());

        wait_drained();
        repeat (40) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("probed_hash_cache_with_decay verification clean");
        else
            $display("probed_hash_cache_with_decay verification failed");
        $finish;
    end

endmodule
